// ----- hw/rtl/nap_pkg.sv -----
package nap_pkg;

   // attribute capacities in bytes
   localparam int unsigned TITLE_CAP_DEF   = 43;
   localparam int unsigned MESSAGE_CAP_DEF = 250;
   localparam int unsigned APPID_CAP_DEF   = 31;
   localparam int unsigned DATE_CAP_DEF    = 15;

   // attribute identifiers
   localparam logic [7:0] ATTR_APP_ID   = 8'd0;
   localparam logic [7:0] ATTR_TITLE    = 8'd1;
   localparam logic [7:0] ATTR_SUBTITLE = 8'd2;
   localparam logic [7:0] ATTR_MESSAGE  = 8'd3;
   localparam logic [7:0] ATTR_DATE     = 8'd5;

   // identifier of the messaging application, first character at index 0
   localparam int unsigned SMS_LEN = 19;
   localparam logic [7:0] SMS_APP_ID [SMS_LEN] = '{
      8'h63, 8'h6F, 8'h6D, 8'h2E, 8'h61, 8'h70, 8'h70, 8'h6C, 8'h65, 8'h2E,
      8'h4D, 8'h6F, 8'h62, 8'h69, 8'h6C, 8'h65, 8'h53, 8'h4D, 8'h53
   };

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_IDLE     = 5'b00001,
      PH_UID      = 5'b00010,
      PH_ATTR_ID  = 5'b00100,
      PH_ATTR_LEN = 5'b01000,
      PH_PAYLOAD  = 5'b10000
   } nap_phase_type;

   // one stream byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } nap_req_type;

   // one result
   typedef struct packed {
      logic       write_valid;
      logic [7:0] attribute_id;
      logic [7:0] offset;
      logic [7:0] stored_byte;
      logic       attribute_end;
      logic       done_res;
      logic       sms_app;
      logic       overflow;
   } nap_rsp_type;

   // attribute id belongs to a stored attribute
   function automatic logic attr_known(input logic [7:0] id);
      return id inside {ATTR_APP_ID, ATTR_TITLE, ATTR_SUBTITLE, ATTR_MESSAGE, ATTR_DATE};
   endfunction

endpackage

// ----- hw/rtl/nap_in_reg.sv -----
module nap_in_reg
   import nap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  nap_req_type req_in,
   input  logic        out_ready,
   output logic        in_valid,
   output nap_req_type req_out
);

   logic        valid_ff, valid_in;
   nap_req_type data_ff;
   logic        load;

   // the stage refills when empty or when its request moves on
   assign load      = !valid_ff || out_ready;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         data_ff <= req_in;
      end
   end

   assign in_valid = valid_ff;
   assign req_out  = data_ff;

endmodule

// ----- hw/rtl/nap_parse.sv -----
module nap_parse
   import nap_pkg::*;
#(
   parameter int unsigned TITLE_CAP   = TITLE_CAP_DEF,
   parameter int unsigned MESSAGE_CAP = MESSAGE_CAP_DEF,
   parameter int unsigned APPID_CAP   = APPID_CAP_DEF,
   parameter int unsigned DATE_CAP    = DATE_CAP_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  nap_req_type req,
   output nap_rsp_type rsp
);

   nap_phase_type phase_ff, phase_in;
   logic [1:0]    fbc_ff, fbc_in;
   logic [7:0]    cur_ff, cur_in;
   logic [15:0]   len_ff, len_in;
   logic [15:0]   rem_ff, rem_in;
   logic          match_ff, match_in;

   logic [15:0]   len_full;
   logic [15:0]   pos;
   logic [7:0]    cap;
   logic          fin;

   // capacity of the attribute being filled
   always_comb begin
      case (cur_ff)
         ATTR_APP_ID:   cap = 8'(APPID_CAP);
         ATTR_TITLE:    cap = 8'(TITLE_CAP);
         ATTR_SUBTITLE: cap = 8'(TITLE_CAP);
         ATTR_MESSAGE:  cap = 8'(MESSAGE_CAP);
         ATTR_DATE:     cap = 8'(DATE_CAP);
         default:       cap = 8'd0;
      endcase
   end

   assign len_full = {req.data_byte, len_ff[7:0]};
   assign pos      = len_ff - rem_ff;

   // next state and result for one byte
   always_comb begin
      phase_in = phase_ff;
      fbc_in   = fbc_ff;
      cur_in   = cur_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      match_in = match_ff;
      fin      = 1'b0;
      rsp      = '0;

      case (phase_ff)
         PH_UID: begin
            fbc_in = fbc_ff + 2'd1;
            if (fbc_ff == 2'd3) begin
               phase_in = PH_ATTR_ID;
            end
         end
         PH_ATTR_ID: begin
            cur_in   = req.data_byte;
            fbc_in   = 2'd0;
            phase_in = PH_ATTR_LEN;
         end
         PH_ATTR_LEN: begin
            if (!fbc_ff[0]) begin
               len_in = {8'd0, req.data_byte};
               fbc_in = 2'd1;
            end else begin
               len_in = len_full;
               fbc_in = 2'd0;
               rem_in = len_full;
               if (cur_ff == ATTR_APP_ID) begin
                  match_in = 1'b1;
               end
               if (len_full == 16'd0) begin
                  fin = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (rem_ff != 16'd0) begin
               if (attr_known(cur_ff)) begin
                  rsp.attribute_id = cur_ff;
                  if (pos < {8'd0, cap}) begin
                     rsp.write_valid = 1'b1;
                     rsp.offset      = pos[7:0];
                     rsp.stored_byte = req.data_byte;
                  end else begin
                     rsp.overflow = 1'b1;
                  end
               end
               if (cur_ff == ATTR_APP_ID) begin
                  if (pos >= 16'(SMS_LEN)) begin
                     match_in = 1'b0;
                  end else if (SMS_APP_ID[pos[4:0]] != req.data_byte) begin
                     match_in = 1'b0;
                  end
               end
               rem_in = rem_ff - 16'd1;
            end
            if (rem_in == 16'd0) begin
               fin = 1'b1;
            end
         end
         default: begin
            // command byte
            fbc_in   = 2'd0;
            phase_in = PH_UID;
         end
      endcase

      // close the attribute
      if (fin) begin
         rsp.attribute_end = attr_known(cur_ff);
         if (cur_ff == ATTR_APP_ID && len_in != 16'(SMS_LEN)) begin
            match_in = 1'b0;
         end
         phase_in = (cur_ff == ATTR_DATE) ? PH_IDLE : PH_ATTR_ID;
      end

      rsp.done_res = req.end_of_packet && (phase_in == PH_IDLE);
      rsp.sms_app  = rsp.done_res && match_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fbc_ff   <= 2'd0;
         cur_ff   <= 8'd0;
         len_ff   <= 16'd0;
         rem_ff   <= 16'd0;
         match_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         fbc_ff   <= fbc_in;
         cur_ff   <= cur_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         match_ff <= match_in;
      end
   end

   // last payload byte always leaves the payload phase
   assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_PAYLOAD && rem_ff == 16'd1 |=> phase_ff != PH_PAYLOAD)
      else $error("payload phase held past last byte");

   // done only when the parser has gone idle
   assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.done_res |=> phase_ff == PH_IDLE)
      else $error("done raised outside idle");

   // a completed attribute leads to the next id or to idle
   assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.attribute_end |=> phase_ff == PH_IDLE || phase_ff == PH_ATTR_ID)
      else $error("attribute end without phase change");

   // a byte is never both written and dropped
   assert property (@(posedge clock) disable iff (reset)
      step_en |-> !(rsp.write_valid && rsp.overflow))
      else $error("write and overflow together");

endmodule

// ----- hw/rtl/nap_out_reg.sv -----
module nap_out_reg
   import nap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  nap_rsp_type rsp_in,
   output logic        out_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output nap_rsp_type rsp_out
);

   logic        valid_ff, valid_in;
   nap_rsp_type data_ff;

   // result register takes a new request when empty or being drained
   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = out_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && in_valid) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

endmodule

// ----- hw/rtl/notification_attribute_parser_top.sv -----
// channel   direction  ports
// req       in         req_valid, req_stall, req_data_byte, req_end_of_packet
// rsp       out        rsp_valid, rsp_stall, rsp_write_valid .. rsp_overflow
//
// one result per request; a request can be taken every cycle while rsp_stall is low
// a request passes through the input register, then the parser logic into the result register
// synchronous active-high reset empties both registers and sets the parser idle
// rsp_stall holds the result register and, once the input register is full, req_stall
module notification_attribute_parser_top
   import nap_pkg::*;
#(
   parameter int unsigned TITLE_CAP   = TITLE_CAP_DEF,
   parameter int unsigned MESSAGE_CAP = MESSAGE_CAP_DEF,
   parameter int unsigned APPID_CAP   = APPID_CAP_DEF,
   parameter int unsigned DATE_CAP    = DATE_CAP_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_packet,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_write_valid,
   output logic [7:0] rsp_attribute_id,
   output logic [7:0] rsp_offset,
   output logic [7:0] rsp_stored_byte,
   output logic       rsp_attribute_end,
   output logic       rsp_done_res,
   output logic       rsp_sms_app,
   output logic       rsp_overflow
);

   nap_req_type req_in, req_q;
   nap_rsp_type rsp_c, rsp_q;
   logic        in_valid;
   logic        out_ready;

   assign req_in.data_byte     = req_data_byte;
   assign req_in.end_of_packet = req_end_of_packet;

   nap_in_reg u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in    (req_in),
      .out_ready (out_ready),
      .in_valid  (in_valid),
      .req_out   (req_q)
   );

   nap_parse #(
      .TITLE_CAP   (TITLE_CAP),
      .MESSAGE_CAP (MESSAGE_CAP),
      .APPID_CAP   (APPID_CAP),
      .DATE_CAP    (DATE_CAP)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (in_valid && out_ready),
      .req     (req_q),
      .rsp     (rsp_c)
   );

   nap_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .rsp_in    (rsp_c),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp_q)
   );

   assign rsp_write_valid   = rsp_q.write_valid;
   assign rsp_attribute_id  = rsp_q.attribute_id;
   assign rsp_offset        = rsp_q.offset;
   assign rsp_stored_byte   = rsp_q.stored_byte;
   assign rsp_attribute_end = rsp_q.attribute_end;
   assign rsp_done_res      = rsp_q.done_res;
   assign rsp_sms_app       = rsp_q.sms_app;
   assign rsp_overflow      = rsp_q.overflow;

endmodule

// ----- tb/tb_notification_attribute_parser_top.sv -----
module tb_notification_attribute_parser_top;
   import nap_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 250000;
   localparam int unsigned RANDOM_BYTES = 850;
   localparam int unsigned HOLD_AT      = 300;
   localparam int unsigned DRAIN_AT     = 400;
   localparam int unsigned QUIET_FROM   = 500;
   localparam int unsigned QUIET_TO     = 650;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_packet = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_write_valid;
   logic [7:0] rsp_attribute_id;
   logic [7:0] rsp_offset;
   logic [7:0] rsp_stored_byte;
   logic       rsp_attribute_end;
   logic       rsp_done_res;
   logic       rsp_sms_app;
   logic       rsp_overflow;

   // one directed stream byte, with the result typed in where it is obvious
   typedef struct {
      logic [7:0] data;
      bit         eop;
      bit         typed;
      bit         att_end;
      bit         done;
   } stream_row_type;

   stream_row_type directed_rows [22] = '{
      '{8'h00,         1'b0, 1'b1, 1'b0, 1'b0},  // command byte
      '{8'hFF,         1'b0, 1'b1, 1'b0, 1'b0},  // uid
      '{8'h00,         1'b0, 1'b1, 1'b0, 1'b0},
      '{8'hFF,         1'b0, 1'b1, 1'b0, 1'b0},
      '{8'h00,         1'b1, 1'b1, 1'b0, 1'b0},  // packet split inside the uid
      '{ATTR_APP_ID,   1'b0, 1'b1, 1'b0, 1'b0},  // zero-length app id
      '{8'h00,         1'b0, 1'b1, 1'b0, 1'b0},
      '{8'h00,         1'b0, 1'b1, 1'b1, 1'b0},
      '{8'hFF,         1'b0, 1'b1, 1'b0, 1'b0},  // unknown attribute, two bytes
      '{8'h02,         1'b0, 1'b1, 1'b0, 1'b0},
      '{8'h00,         1'b0, 1'b1, 1'b0, 1'b0},
      '{8'hA5,         1'b0, 1'b1, 1'b0, 1'b0},
      '{8'h5A,         1'b1, 1'b1, 1'b0, 1'b0},  // split inside the payload
      '{ATTR_TITLE,    1'b0, 1'b0, 1'b0, 1'b0},  // one-byte title
      '{8'h01,         1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00,         1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hFF,         1'b0, 1'b0, 1'b0, 1'b0},
      '{ATTR_DATE,     1'b0, 1'b0, 1'b0, 1'b0},  // two-byte date closes the packet
      '{8'h02,         1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00,         1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00,         1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hFF,         1'b1, 1'b0, 1'b0, 1'b0}
   };

   // parser state as the predictor sees it
   nap_phase_type ph       = PH_IDLE;
   logic [1:0]    fld_cnt  = 2'd0;
   logic [7:0]    cur_id   = 8'h00;
   logic [15:0]   val_len  = 16'h0000;
   logic [15:0]   val_left = 16'h0000;
   logic          sms_hit  = 1'b0;

   nap_rsp_type pending_results [$];
   int unsigned accepted_reqs = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int          byte_budget = -1;
   int unsigned n_writes = 0, n_overflows = 0, n_ends = 0, n_done = 0, n_sms = 0;

   notification_attribute_parser_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_packet (req_end_of_packet),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_attribute_id  (rsp_attribute_id),
      .rsp_offset        (rsp_offset),
      .rsp_stored_byte   (rsp_stored_byte),
      .rsp_attribute_end (rsp_attribute_end),
      .rsp_done_res      (rsp_done_res),
      .rsp_sms_app       (rsp_sms_app),
      .rsp_overflow      (rsp_overflow)
   );

   always #4 clock = ~clock;

   // storage space per attribute, zero for ids that are not stored
   function automatic int unsigned capacity_of(logic [7:0] id);
      case (id)
         ATTR_APP_ID:               return APPID_CAP_DEF;
         ATTR_TITLE, ATTR_SUBTITLE: return TITLE_CAP_DEF;
         ATTR_MESSAGE:              return MESSAGE_CAP_DEF;
         ATTR_DATE:                 return DATE_CAP_DEF;
         default:                   return 0;
      endcase
   endfunction

   // attribute value complete: settle the sms match and move on
   function automatic void close_attribute(inout nap_rsp_type r);
      if (capacity_of(cur_id) != 0) r.attribute_end = 1'b1;
      if (cur_id == ATTR_APP_ID && val_len != SMS_LEN) sms_hit = 1'b0;
      ph = (cur_id == ATTR_DATE) ? PH_IDLE : PH_ATTR_ID;
   endfunction

   // advance the parser by one stream byte and return the result it gives
   function automatic nap_rsp_type parse_byte(logic [7:0] b, logic eop);
      nap_rsp_type r;
      int unsigned pos;
      r = '0;
      case (ph)
         PH_UID: begin
            fld_cnt = fld_cnt + 2'd1;
            if (fld_cnt == 2'd0) ph = PH_ATTR_ID;
         end
         PH_ATTR_ID: begin
            cur_id = b;
            fld_cnt = 2'd0;
            ph = PH_ATTR_LEN;
         end
         PH_ATTR_LEN: begin
            if (!fld_cnt[0]) begin
               val_len = {8'h00, b};
               fld_cnt = 2'd1;
            end else begin
               val_len[15:8] = b;
               fld_cnt = 2'd0;
               val_left = val_len;
               if (cur_id == ATTR_APP_ID) sms_hit = 1'b1;
               if (val_len == 16'h0000) close_attribute(r);
               else ph = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            pos = 32'(val_len - val_left);
            if (val_left != 16'h0000) begin
               if (capacity_of(cur_id) != 0) begin
                  r.attribute_id = cur_id;
                  if (pos < capacity_of(cur_id)) begin
                     r.write_valid = 1'b1;
                     r.offset = pos[7:0];
                     r.stored_byte = b;
                  end else begin
                     r.overflow = 1'b1;
                  end
               end
               if (cur_id == ATTR_APP_ID && (pos >= SMS_LEN || SMS_APP_ID[pos] != b))
                  sms_hit = 1'b0;
               val_left = val_left - 16'd1;
            end
            if (val_left == 16'h0000) close_attribute(r);
         end
         default: begin
            fld_cnt = 2'd0;
            ph = PH_UID;
         end
      endcase
      r.done_res = eop && (ph == PH_IDLE);
      r.sms_app = r.done_res && sms_hit;
      return r;
   endfunction

   function automatic bit in_quiet();
      return accepted_reqs >= QUIET_FROM && accepted_reqs < QUIET_TO;
   endfunction

   // occasional end of packet in the middle of a notification
   function automatic bit split();
      return $urandom_range(99) < 3;
   endfunction

   // offer one request, wait for it to be taken, queue what it should give
   task automatic send_byte(logic [7:0] b, logic eop, bit typed = 1'b0,
                            nap_rsp_type typed_rsp = '0);
      nap_rsp_type predicted;
      bit taken;
      if (byte_budget == 0) return;
      if (byte_budget > 0) byte_budget--;
      if (!in_quiet()) begin
         while ($urandom_range(99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_packet <= eop;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      predicted = parse_byte(b, eop);
      pending_results.push_back(typed ? typed_rsp : predicted);
      accepted_reqs++;
   endtask

   // lengths biased towards empty, the capacity edges and the sms name
   function automatic int pick_length(logic [7:0] id);
      int unsigned cap;
      int r;
      cap = capacity_of(id);
      r = $urandom_range(99);
      if (cap == 0) return $urandom_range(0, 6);
      if (id == ATTR_APP_ID && r < 50) return SMS_LEN;
      if (id == ATTR_APP_ID && r < 60) return SMS_LEN - 1 + 2 * $urandom_range(0, 1);
      if (r < 15) return 0;
      if (r < 30) return cap - 1 + $urandom_range(0, 2);
      if (id == ATTR_MESSAGE && r < 36) return $urandom_range(256, 300);
      return $urandom_range(1, (cap < 20) ? cap : 20);
   endfunction

   task automatic send_attribute(logic [7:0] id, int len, bit eop_last);
      logic [7:0] val;
      int bad_pos;
      bit sms_like;
      sms_like = (id == ATTR_APP_ID) && ($urandom_range(99) < 75);
      bad_pos = ($urandom_range(99) < 25) ? $urandom_range(0, SMS_LEN - 1) : -1;
      send_byte(id, split());
      send_byte(len[7:0], split());
      send_byte(len[15:8], (eop_last && len == 0) ? 1'b1 : split());
      for (int i = 0; i < len; i++) begin
         if (sms_like && i < SMS_LEN)
            val = SMS_APP_ID[i] ^ ((i == bad_pos) ? 8'($urandom_range(1, 255)) : 8'h00);
         else
            val = 8'($urandom_range(255));
         send_byte(val, (eop_last && i == len - 1) ? 1'b1 : split());
      end
   endtask

   // command, uid, a few attributes, then the date
   task automatic send_packet();
      int n_attr;
      int r;
      logic [7:0] id;
      repeat (5) send_byte(8'($urandom_range(255)), split());
      n_attr = $urandom_range(0, 5);
      repeat (n_attr) begin
         r = $urandom_range(99);
         if (r < 25) id = ATTR_APP_ID;
         else if (r < 45) id = ATTR_TITLE;
         else if (r < 60) id = ATTR_SUBTITLE;
         else if (r < 80) id = ATTR_MESSAGE;
         else begin
            id = 8'($urandom_range(255));
            while (capacity_of(id) != 0) id = 8'($urandom_range(255));
         end
         send_attribute(id, pick_length(id), 1'b0);
      end
      send_attribute(ATTR_DATE, pick_length(ATTR_DATE), 1'b1);
   endtask

   // steer the parser back to idle after noise or a cut packet
   task automatic resync();
      while (ph != PH_IDLE) begin
         case (ph)
            PH_ATTR_ID:  send_byte(ATTR_DATE, 1'($urandom_range(1)));
            PH_ATTR_LEN: send_byte(8'h00, 1'($urandom_range(1)));
            default:     send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         endcase
      end
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // result side: sample before the edge that takes the result
   always @(negedge clock) begin
      nap_rsp_type got;
      nap_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_write_valid, rsp_attribute_id, rsp_offset, rsp_stored_byte,
                rsp_attribute_end, rsp_done_res, rsp_sms_app, rsp_overflow};
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("write_valid", 8'(want.write_valid), 8'(got.write_valid));
            check_field("attribute_id", want.attribute_id, got.attribute_id);
            check_field("offset", want.offset, got.offset);
            check_field("stored_byte", want.stored_byte, got.stored_byte);
            check_field("attribute_end", 8'(want.attribute_end), 8'(got.attribute_end));
            check_field("done_res", 8'(want.done_res), 8'(got.done_res));
            check_field("sms_app", 8'(want.sms_app), 8'(got.sms_app));
            check_field("overflow", 8'(want.overflow), 8'(got.overflow));
         end
         n_writes += got.write_valid;
         n_overflows += got.overflow;
         n_ends += got.attribute_end;
         n_done += got.done_res;
         n_sms += got.sms_app;
      end
   end

   // receiver: random stalls, one long hold-off, one quiet stretch
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_used && accepted_reqs >= HOLD_AT) begin
            hold_left = 120;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (in_quiet()) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 33);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("notification_attribute_parser_top regression: fail");
         $finish;
      end
   end

   // sender and end of run
   initial begin
      nap_rsp_type row_rsp;
      bit drained;
      int kind;
      drained = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed stream
      foreach (directed_rows[i]) begin
         row_rsp = '0;
         row_rsp.attribute_end = directed_rows[i].att_end;
         row_rsp.done_res = directed_rows[i].done;
         send_byte(directed_rows[i].data, directed_rows[i].eop,
                   directed_rows[i].typed, row_rsp);
      end

      // random notifications, cut packets and noise
      while (accepted_reqs < $size(directed_rows) + RANDOM_BYTES) begin
         if (!drained && accepted_reqs >= DRAIN_AT) begin
            while (pending_results.size() != 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
            drained = 1'b1;
         end
         kind = $urandom_range(99);
         if (kind < 80) begin
            send_packet();
         end else if (kind < 90) begin
            byte_budget = $urandom_range(1, 40);
            send_packet();
            byte_budget = -1;
            resync();
         end else begin
            repeat ($urandom_range(1, 7))
               send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            resync();
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d requests: %0d stored bytes, %0d overflows, %0d attribute ends",
               accepted_reqs, n_writes, n_overflows, n_ends);
      $display("%0d notifications completed, %0d from the messaging app", n_done, n_sms);
      if (mismatches == 0) begin
         $display("notification_attribute_parser_top regression: pass");
      end else begin
         $display("notification_attribute_parser_top regression: fail");
      end
      $finish;
   end

endmodule
